// File: hdl/c3f_pkg.sv
// shared types and constants for the 3x3 convolution filter
// no dependencies; the other files, apart from c3f_ram, refer to this package by scoped names

package c3f_pkg;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 8;
    localparam int PROD_W     = 17;
    localparam int CONV_W     = 20;
    localparam int KROW_W     = 24;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int MIN_SIZE   = 3;

    // sobel-x after reset, left column in the low byte
    localparam logic [KROW_W-1:0] KTOP_RESET = 24'h0100FF;
    localparam logic [KROW_W-1:0] KMID_RESET = 24'h0200FE;
    localparam logic [KROW_W-1:0] KBOT_RESET = 24'h0100FF;
    localparam logic [FW_W-1:0]   FW_RESET   = 11'd640;
    localparam logic [FH_W-1:0]   FH_RESET   = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KTOP   = 3'd0,
        CFG_KMID   = 3'd1,
        CFG_KBOT   = 3'd2,
        CFG_WIDTH  = 3'd3,
        CFG_HEIGHT = 3'd4
    } cfg_idx_t;

    // window[row][col], row 0 is the oldest line, col 0 the oldest column
    typedef logic [2:0][2:0][PIX_W-1:0] window_t;

    // kernel[row], three signed bytes per row
    typedef logic [2:0][KROW_W-1:0] kernel_t;

    typedef struct packed {
        logic valid;
        logic done;
    } c3f_tag_t;

endpackage

// File: hdl/c3f_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module c3f_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/c3f_window.sv
// raster counters, two line stores and the 3x3 pixel window
// depends on c3f_pkg and c3f_ram

module c3f_window #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [c3f_pkg::PIX_W-1:0]     pixel,
    input  logic [$clog2(MAX_WIDTH):0]    width_lim,
    input  logic [$clog2(MAX_HEIGHT):0]   height_lim,
    output c3f_pkg::window_t              win,
    output c3f_pkg::c3f_tag_t             tag,
    input  logic                          mac_ready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          last_col, last_row, emit, accept;

    logic                      s1_v_reg;
    logic [c3f_pkg::PIX_W-1:0] s1_pix_reg;
    logic [CW-1:0]             s1_addr_reg;
    logic                      s1_emit_reg;
    logic                      s1_done_reg;
    logic                      s1_go, s1_ready, s2_ready;

    logic [c3f_pkg::PIX_W-1:0] up1, up2;

    logic              s2_v_reg, s2_done_reg;
    c3f_pkg::window_t  win_reg, win_next;

    assign s2_ready = !s2_v_reg || mac_ready;
    assign s1_ready = !s1_v_reg || s2_ready;
    assign s1_go    = s1_v_reg && s2_ready;
    assign accept   = in_valid && s1_ready;
    assign in_stall = !s1_ready;

    assign last_col = ({1'b0, col_reg} + (CW + 1)'(1)) >= width_lim;
    assign last_row = ({1'b0, row_reg} + (RW + 1)'(1)) >= height_lim;
    assign emit     = (row_reg >= RW'(2)) && (col_reg >= CW'(2));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + RW'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_v_reg <= accept || (s1_v_reg && !s2_ready);
            if (s2_ready)
            begin
                s2_v_reg <= s1_v_reg && s1_emit_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pixel;
            s1_addr_reg <= col_reg;
            s1_emit_reg <= emit;
            s1_done_reg <= last_col && last_row;
        end
        if (s1_go)
        begin
            win_reg     <= win_next;
            s2_done_reg <= s1_done_reg;
        end
    end

    // line store a holds the row above, b the row two above
    c3f_ram #(
        .WIDTH (c3f_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_addr_reg),
        .wdata (s1_pix_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (up1)
    );

    c3f_ram #(
        .WIDTH (c3f_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_addr_reg),
        .wdata (up1),
        .re    (accept),
        .raddr (col_reg),
        .rdata (up2)
    );

    always_comb
    begin
        win_next = win_reg;
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = up2;
        win_next[1][2] = up1;
        win_next[2][2] = s1_pix_reg;
    end

    assign win       = win_reg;
    assign tag.valid = s2_v_reg;
    assign tag.done  = s2_done_reg;

endmodule

// File: hdl/c3f_mac.sv
// nine pixel-by-coefficient products, their sum and the output register
// depends on c3f_pkg

module c3f_mac (
    input  logic                             clk,
    input  logic                             rst_n,
    input  c3f_pkg::window_t                 win,
    input  c3f_pkg::c3f_tag_t                tag,
    output logic                             ready,
    input  c3f_pkg::kernel_t                 kernel,
    output logic signed [c3f_pkg::CONV_W-1:0] conv_value,
    output logic                             frame_done,
    output logic                             out_valid,
    input  logic                             out_stall
);

    localparam int PW = c3f_pkg::PROD_W;
    localparam int SW = c3f_pkg::CONV_W;

    logic signed [PW-1:0] prod_reg  [3][3];
    logic signed [PW-1:0] prod_next [3][3];
    logic                 s3_v_reg, s3_done_reg;

    logic signed [SW-1:0] sum_next;
    logic signed [SW-1:0] conv_reg;
    logic                 done_reg, out_v_reg;
    logic                 out_ready, s3_ready;

    assign out_ready = !out_v_reg || !out_stall;
    assign s3_ready  = !s3_v_reg || out_ready;
    assign ready     = s3_ready;

    always_comb
    begin
        logic signed [PW-1:0] px_s;
        logic signed [PW-1:0] cf_s;
        px_s = '0;
        cf_s = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                px_s = PW'($signed({1'b0, win[i][j]}));
                cf_s = PW'($signed(kernel[i][8*j +: c3f_pkg::COEF_W]));
                prod_next[i][j] = px_s * cf_s;
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sum_next = sum_next + SW'(prod_reg[i][j]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
            begin
                s3_v_reg <= tag.valid;
            end
            if (out_ready)
            begin
                out_v_reg <= s3_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && tag.valid)
        begin
            prod_reg    <= prod_next;
            s3_done_reg <= tag.done;
        end
        if (out_ready && s3_v_reg)
        begin
            conv_reg <= sum_next;
            done_reg <= s3_done_reg;
        end
    end

    assign conv_value = conv_reg;
    assign frame_done = done_reg;
    assign out_valid  = out_v_reg;

endmodule

// File: hdl/conv3x3_image_filter_top.sv
// top level of the 3x3 convolution filter: configuration registers and stage wiring
// depends on c3f_pkg, c3f_window, c3f_mac
//
//  channel  direction  handshake             payload
//  -------  ---------  --------------------  ------------------------------
//  in       sink       in_valid / in_stall   pixel[7:0]
//  out      source     out_valid / out_stall conv_value[19:0], frame_done
//  cfg      sink       cfg_valid / cfg_ready cfg_index[2:0], cfg_data[23:0]
//
// one pixel word per cycle is taken while in_stall is low; the result for the word that
// completes an interior window passes the input and line-store read register, then the
// window, multiply and sum registers. border pixels give no result.
// reset loads the sobel-x kernel and a 640x480 frame and zeroes the counters;
// the line stores need no clearing pass.
// out_stall holds the output register and backs up through the stages to in_stall.

module conv3x3_image_filter_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [c3f_pkg::PIX_W-1:0]             pixel,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [c3f_pkg::CONV_W-1:0]     conv_value,
    output logic                                  frame_done,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [c3f_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [c3f_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int WL  = $clog2(MAX_WIDTH) + 1;
    localparam int HL  = $clog2(MAX_HEIGHT) + 1;
    localparam int LWW = (WL > c3f_pkg::FW_W) ? WL : c3f_pkg::FW_W;
    localparam int LWH = (HL > c3f_pkg::FH_W) ? HL : c3f_pkg::FH_W;

    logic [c3f_pkg::KROW_W-1:0] ktop_reg, kmid_reg, kbot_reg;
    logic [c3f_pkg::FW_W-1:0]   fw_reg;
    logic [c3f_pkg::FH_W-1:0]   fh_reg;

    logic [LWW-1:0] fw_ext;
    logic [LWH-1:0] fh_ext;
    logic [WL-1:0]  width_lim;
    logic [HL-1:0]  height_lim;

    c3f_pkg::window_t  win;
    c3f_pkg::c3f_tag_t tag;
    c3f_pkg::kernel_t  kernel;
    logic              mac_ready;
    logic              cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ktop_reg <= c3f_pkg::KTOP_RESET;
            kmid_reg <= c3f_pkg::KMID_RESET;
            kbot_reg <= c3f_pkg::KBOT_RESET;
            fw_reg   <= c3f_pkg::FW_RESET;
            fh_reg   <= c3f_pkg::FH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (c3f_pkg::cfg_idx_t'(cfg_index))
                c3f_pkg::CFG_KTOP:   ktop_reg <= cfg_data;
                c3f_pkg::CFG_KMID:   kmid_reg <= cfg_data;
                c3f_pkg::CFG_KBOT:   kbot_reg <= cfg_data;
                c3f_pkg::CFG_WIDTH:  fw_reg   <= cfg_data[c3f_pkg::FW_W-1:0];
                c3f_pkg::CFG_HEIGHT: fh_reg   <= cfg_data[c3f_pkg::FH_W-1:0];
                default: ;
            endcase
        end
    end

    // sizes outside the supported range are clamped
    always_comb
    begin
        fw_ext = LWW'(fw_reg);
        fh_ext = LWH'(fh_reg);
        priority if (fw_ext < LWW'(c3f_pkg::MIN_SIZE))
            width_lim = WL'(c3f_pkg::MIN_SIZE);
        else if (fw_ext > LWW'(MAX_WIDTH))
            width_lim = WL'(MAX_WIDTH);
        else
            width_lim = WL'(fw_ext);
        priority if (fh_ext < LWH'(c3f_pkg::MIN_SIZE))
            height_lim = HL'(c3f_pkg::MIN_SIZE);
        else if (fh_ext > LWH'(MAX_HEIGHT))
            height_lim = HL'(MAX_HEIGHT);
        else
            height_lim = HL'(fh_ext);
    end

    assign kernel[0] = ktop_reg;
    assign kernel[1] = kmid_reg;
    assign kernel[2] = kbot_reg;

    c3f_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .width_lim  (width_lim),
        .height_lim (height_lim),
        .win        (win),
        .tag        (tag),
        .mac_ready  (mac_ready)
    );

    c3f_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .win        (win),
        .tag        (tag),
        .ready      (mac_ready),
        .kernel     (kernel),
        .conv_value (conv_value),
        .frame_done (frame_done),
        .out_valid  (out_valid),
        .out_stall  (out_stall)
    );

endmodule

// File: hdl/c3f_checker.sv
// port-level checks for the 3x3 convolution filter, bound to the top level
// depends on c3f_pkg and conv3x3_image_filter_top

module c3f_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_stall,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic signed [c3f_pkg::CONV_W-1:0]     conv_value,
    input logic                                  frame_done
);

    // no result word once reset has been seen at an edge
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high during reset");

    // the input only backs up when a finished word is held at the output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a stalled output word");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(conv_value) && $stable(frame_done)))
        else $error("output payload changed while stalled");

endmodule

bind conv3x3_image_filter_top c3f_checker u_c3f_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for conv3x3_image_filter_top: random pixel frames, kernels and sizes
// against an in-bench convolution predictor; depends on c3f_pkg and the filter rtl

module tb_top;

    localparam int MAX_W        = 1024;
    localparam int MAX_H        = 4096;
    localparam int RANDOM_ITEMS = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 600000;

    localparam int PIX_W      = c3f_pkg::PIX_W;
    localparam int CONV_W     = c3f_pkg::CONV_W;
    localparam int KROW_W     = c3f_pkg::KROW_W;
    localparam int FW_W       = c3f_pkg::FW_W;
    localparam int FH_W       = c3f_pkg::FH_W;
    localparam int CFG_IDX_W  = c3f_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = c3f_pkg::CFG_DATA_W;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } pause_mode_t;

    typedef struct {
        logic signed [CONV_W-1:0] value;
        logic                     done;
    } conv_result_t;

    logic                        clk;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [PIX_W-1:0]            pixel = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [CONV_W-1:0]    conv_value;
    logic                        frame_done;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;

    // predictor copy of the registers and the filter state
    c3f_pkg::kernel_t            kernel_rows;
    logic [FW_W-1:0]             width_reg;
    logic [FH_W-1:0]             height_reg;
    logic [PIX_W-1:0]            line_prev [MAX_W];
    logic [PIX_W-1:0]            line_prev2 [MAX_W];
    c3f_pkg::window_t            win;
    int                          col_pos;
    int                          row_pos;

    logic [PIX_W-1:0]            pixel_queue [$];
    conv_result_t                conv_due [$];
    pause_mode_t                 pause_mode = IDLE_NONE;
    bit                          pixel_taken = 1'b0;
    int                          mismatches = 0;
    int                          cycle_count = 0;

    conv3x3_image_filter_top #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .conv_value (conv_value),
        .frame_done (frame_done),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int eff_width();
        int v;
        v = int'(width_reg);
        return (v < c3f_pkg::MIN_SIZE) ? c3f_pkg::MIN_SIZE : (v > MAX_W) ? MAX_W : v;
    endfunction

    function automatic int eff_height();
        int v;
        v = int'(height_reg);
        return (v < c3f_pkg::MIN_SIZE) ? c3f_pkg::MIN_SIZE : (v > MAX_H) ? MAX_H : v;
    endfunction

    // shift the window, update the line stores and queue the sum for interior pixels
    task automatic convolve_pixel(input logic [PIX_W-1:0] px);
        int             w;
        int             h;
        int             c;
        int             r;
        int             idx;
        int             sum;
        logic [PIX_W-1:0] up1;
        logic [PIX_W-1:0] up2;
        bit             last_col;
        bit             last_row;
        conv_result_t   res;
        w = eff_width();
        h = eff_height();
        c = col_pos;
        r = row_pos;
        idx = c % MAX_W;
        up1 = line_prev[idx];
        up2 = line_prev2[idx];
        last_col = (c + 1 >= w);
        last_row = (r + 1 >= h);
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up2;
        win[1][2] = up1;
        win[2][2] = px;
        line_prev2[idx] = up1;
        line_prev[idx] = px;
        if (r >= 2 && c >= 2)
        begin
            sum = 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    sum += int'(win[i][j]) * int'($signed(kernel_rows[i][8*j +: 8]));
            res.value = sum[CONV_W-1:0];
            res.done = last_col && last_row;
            conv_due.push_back(res);
        end
        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
    endtask

    // pixels still needed to bring the counters back to the start of a frame
    function automatic int pixels_to_frame_end();
        int n;
        int c;
        int r;
        int w;
        int h;
        n = 0;
        c = col_pos;
        r = row_pos;
        w = eff_width();
        h = eff_height();
        while (c != 0 || r != 0)
        begin
            n++;
            if (c + 1 >= w)
            begin
                c = 0;
                r = (r + 1 >= h) ? 0 : r + 1;
            end
            else
                c++;
        end
        return n;
    endfunction

    function automatic bit roll_pause(input bit sender);
        int pct;
        if (pause_mode == IDLE_BOTH)
            pct = 16;
        else if (pause_mode == (sender ? IDLE_SEND : IDLE_RECV))
            pct = 84;
        else
            pct = 0;
        return $urandom_range(99) < pct;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [KROW_W-1:0] pick_kernel_row();
        case ($urandom_range(7))
            0: return 24'h7F7F7F;
            1: return 24'h808080;
            default: return KROW_W'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            c3f_pkg::CFG_KTOP:   kernel_rows[0] = data;
            c3f_pkg::CFG_KMID:   kernel_rows[1] = data;
            c3f_pkg::CFG_KBOT:   kernel_rows[2] = data;
            c3f_pkg::CFG_WIDTH:  width_reg = data[FW_W-1:0];
            c3f_pkg::CFG_HEIGHT: height_reg = data[FH_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // size words carry random upper bits that the registers must drop
    task automatic set_size(input int w_raw, input int h_raw);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        data[FW_W-1:0] = FW_W'(w_raw);
        write_reg(c3f_pkg::CFG_WIDTH, data);
        data = CFG_DATA_W'($urandom);
        data[FH_W-1:0] = FH_W'(h_raw);
        write_reg(c3f_pkg::CFG_HEIGHT, data);
    endtask

    task automatic load_kernel();
        write_reg(c3f_pkg::CFG_KTOP, pick_kernel_row());
        write_reg(c3f_pkg::CFG_KMID, pick_kernel_row());
        write_reg(c3f_pkg::CFG_KBOT, pick_kernel_row());
    endtask

    task automatic push_pixels(input int n);
        for (int i = 0; i < n; i++)
            pixel_queue.push_back(rand_pixel());
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pixel_queue.size() != 0 || in_valid || conv_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // pixel driver: accept at the rising edge, present the next word at the falling edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            convolve_pixel(pixel);
            void'(pixel_queue.pop_front());
            pixel_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (!(in_valid && !pixel_taken))
        begin
            pixel_taken = 1'b0;
            if (pixel_queue.size() != 0 && !roll_pause(1'b1))
            begin
                in_valid <= 1'b1;
                pixel <= pixel_queue[0];
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= roll_pause(1'b0);
    end

    // result monitor
    always @(posedge clk)
    begin
        conv_result_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (conv_due.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %0d frame_done %0b",
                         $time, conv_value, frame_done);
                mismatches++;
            end
            else
            begin
                due = conv_due.pop_front();
                if (conv_value !== due.value)
                begin
                    $display("%0t: conv_value expected %0d actual %0d",
                             $time, due.value, conv_value);
                    mismatches++;
                end
                if (frame_done !== due.done)
                begin
                    $display("%0t: frame_done expected %0b actual %0b",
                             $time, due.done, frame_done);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("conv3x3_image_filter_top: mismatch");
            $finish;
        end
    end

    initial
    begin
        int random_items;
        int phase;
        int frame_px;
        int part;
        int rest;
        kernel_rows[0] = c3f_pkg::KTOP_RESET;
        kernel_rows[1] = c3f_pkg::KMID_RESET;
        kernel_rows[2] = c3f_pkg::KBOT_RESET;
        width_reg = c3f_pkg::FW_RESET;
        height_reg = c3f_pkg::FH_RESET;
        col_pos = 0;
        row_pos = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset kernel and reset width: one row and a word, then shrink mid-frame,
        // so the position the counters reached shows in the results
        push_pixels(eff_width() + 1);
        wait_idle();
        set_size(5, 4);
        push_pixels(pixels_to_frame_end());
        wait_idle();

        // smallest frame (sizes below range clamp), unused register indexes
        set_size(0, 2);
        for (int k = int'(c3f_pkg::CFG_HEIGHT) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
        write_reg(c3f_pkg::CFG_KTOP, 24'h7F7F7F);
        write_reg(c3f_pkg::CFG_KMID, 24'h7F7F7F);
        write_reg(c3f_pkg::CFG_KBOT, 24'h7F7F7F);
        repeat (9) pixel_queue.push_back('1);
        wait_idle();
        write_reg(c3f_pkg::CFG_KTOP, 24'h808080);
        write_reg(c3f_pkg::CFG_KMID, 24'h808080);
        write_reg(c3f_pkg::CFG_KBOT, 24'h808080);
        repeat (9) pixel_queue.push_back('1);
        wait_idle();
        write_reg(c3f_pkg::CFG_KTOP, c3f_pkg::KTOP_RESET);
        write_reg(c3f_pkg::CFG_KMID, c3f_pkg::KMID_RESET);
        write_reg(c3f_pkg::CFG_KBOT, c3f_pkg::KBOT_RESET);
        for (int i = 0; i < 9; i++)
            pixel_queue.push_back((i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'h80 : 8'hFF);
        wait_idle();

        // random frames, rotating through the idle patterns
        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            pause_mode = pause_mode_t'(phase % 4);
            load_kernel();
            set_size($urandom_range(10), $urandom_range(8));
            frame_px = eff_width() * eff_height();
            part = $urandom_range(1, 3) * frame_px;
            push_pixels(part);
            random_items += part;
            if ($urandom_range(3) == 0)
            begin
                // stop inside a frame, then set a width no wider than the old one and a new random height
                part = $urandom_range(1, frame_px - 1);
                push_pixels(part);
                wait_idle();
                set_size($urandom_range(eff_width()), $urandom_range(10));
                rest = pixels_to_frame_end();
                push_pixels(rest);
                random_items += part + rest;
            end
            wait_idle();
            phase++;
        end

        if (mismatches == 0)
            $display("conv3x3_image_filter_top: match");
        else
            $display("conv3x3_image_filter_top: mismatch");
        $finish;
    end

endmodule
